### rtl/vlcp_pkg.sv
// ----------------------------------------------------------------------------
// vlcp_pkg
// Types and constants shared by the variable-length code packer modules.
// ----------------------------------------------------------------------------
package vlcp_pkg;

	localparam int DEF_SYMBOL_BITS   = 12;
	localparam int DEF_WORD_BITS     = 64;
	localparam int DEF_MAX_CODE_BITS = 32;

	localparam logic [15:0] BUFFER_WORDS_RESET = 16'hFFFF;

	typedef enum logic [1:0] {
		CMD_LOAD   = 2'd0,
		CMD_ENCODE = 2'd1,
		CMD_FINISH = 2'd2
	} cmd_t;

	typedef struct packed {
		logic [1:0]  cmd;
		logic [11:0] symbol;
		logic [31:0] code_bits;
		logic [5:0]  code_length;
	} sym_item_t;

	typedef struct packed {
		logic [63:0] packed_word;
		logic        is_final;
		logic [31:0] total_bits;
		logic        overflow;
	} word_item_t;

	typedef struct packed {
		logic valid;
		cmd_t cmd;
	} issue_t;

endpackage

### rtl/vlcp_table.sv
// ----------------------------------------------------------------------------
// vlcp_table
// Code table memory: one write port for loads, one registered read port.
// ----------------------------------------------------------------------------
module vlcp_table #(
	parameter int ADDR_W = 12,
	parameter int CODE_W = 32,
	parameter int LEN_W  = 6
) (
	input  logic              clk,
	input  logic              wr_en,
	input  logic [ADDR_W-1:0] wr_addr,
	input  logic [CODE_W-1:0] wr_code,
	input  logic [LEN_W-1:0]  wr_len,
	input  logic              rd_en,
	input  logic [ADDR_W-1:0] rd_addr,
	output logic [CODE_W-1:0] rd_code,
	output logic [LEN_W-1:0]  rd_len
);

	localparam int DEPTH = 1 << ADDR_W;

	logic [CODE_W+LEN_W-1:0] mem [DEPTH];
	logic [CODE_W+LEN_W-1:0] rd_data_q;

	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem[wr_addr] <= {wr_code, wr_len};
		end
	end

	always_ff @(posedge clk) begin
		if (rd_en) begin
			rd_data_q <= mem[rd_addr];
		end
	end

	assign rd_code = rd_data_q[CODE_W+LEN_W-1:LEN_W];
	assign rd_len  = rd_data_q[LEN_W-1:0];

endmodule

### rtl/vlcp_packer.sv
// ----------------------------------------------------------------------------
// vlcp_packer
// Holds the looked-up item, merges its code into the current word, counts
// bits and words, and registers the emitted word.
// ----------------------------------------------------------------------------
module vlcp_packer #(
	parameter int WORD_BITS = 64,
	parameter int CODE_W    = 32,
	parameter int LEN_W     = 6
) (
	input  logic                clk,
	input  logic                arst_n,
	input  logic [15:0]         buffer_words,
	input  vlcp_pkg::issue_t    issue,
	output logic                s1_free,
	input  logic [CODE_W-1:0]   rd_code,
	input  logic [LEN_W-1:0]    rd_len,
	output logic                word_valid,
	input  logic                word_ready,
	output vlcp_pkg::word_item_t word_item
);
	import vlcp_pkg::*;

	localparam int POS_W = $clog2(WORD_BITS);
	localparam int SUM_W = POS_W + 1;
	localparam int CMB_W = WORD_BITS + CODE_W;

	logic                 v_s1;
	cmd_t                 cmd_s1;
	logic [WORD_BITS-1:0] cur_q;
	logic [POS_W-1:0]     bit_pos_q;
	logic [31:0]          total_q;
	logic [16:0]          words_q;
	logic                 out_valid_q;
	word_item_t           out_q;

	logic                 fire;
	logic [CMB_W-1:0]     combined;
	logic [SUM_W-1:0]     pos_sum;
	logic [WORD_BITS-1:0] word_or;
	logic                 word_full;
	logic [32:0]          total_sum;
	logic [31:0]          total_sat;
	logic [16:0]          words_inc;

	assign fire    = v_s1 && (!out_valid_q || word_ready);
	assign s1_free = !v_s1 || fire;

	always_comb begin
		combined  = CMB_W'(rd_code) << bit_pos_q;
		pos_sum   = SUM_W'(bit_pos_q) + SUM_W'(rd_len);
		word_or   = cur_q | combined[WORD_BITS-1:0];
		word_full = pos_sum >= SUM_W'(WORD_BITS);
		total_sum = {1'b0, total_q} + 33'(rd_len);
		total_sat = total_sum[32] ? '1 : total_sum[31:0];
		words_inc = (words_q == '1) ? words_q : words_q + 17'd1;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1   <= 1'b0;
			cmd_s1 <= CMD_LOAD;
		end else if (issue.valid) begin
			v_s1   <= 1'b1;
			cmd_s1 <= issue.cmd;
		end else if (fire) begin
			v_s1   <= 1'b0;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cur_q     <= '0;
			bit_pos_q <= '0;
			total_q   <= '0;
			words_q   <= '0;
		end else if (fire) begin
			case (cmd_s1)
				CMD_ENCODE: begin
					total_q <= total_sat;
					if (word_full) begin
						cur_q     <= WORD_BITS'(combined[CMB_W-1:WORD_BITS]);
						bit_pos_q <= POS_W'(pos_sum - SUM_W'(WORD_BITS));
						words_q   <= words_inc;
					end else begin
						cur_q     <= word_or;
						bit_pos_q <= pos_sum[POS_W-1:0];
					end
				end
				CMD_FINISH: begin
					cur_q     <= '0;
					bit_pos_q <= '0;
					total_q   <= '0;
					words_q   <= '0;
				end
				default: begin
				end
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (fire && (cmd_s1 == CMD_FINISH || word_full)) begin
			out_valid_q <= 1'b1;
		end else if (word_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (fire) begin
			if (cmd_s1 == CMD_FINISH) begin
				out_q.packed_word <= 64'(cur_q);
				out_q.is_final    <= 1'b1;
				out_q.total_bits  <= total_q;
				out_q.overflow    <= words_q >= {1'b0, buffer_words};
			end else if (word_full) begin
				out_q.packed_word <= 64'(word_or);
				out_q.is_final    <= 1'b0;
				out_q.total_bits  <= total_sat;
				out_q.overflow    <= words_inc >= {1'b0, buffer_words};
			end
		end
	end

	assign word_valid = out_valid_q;
	assign word_item  = out_q;

endmodule

### rtl/variable_length_code_packer_top.sv
// ----------------------------------------------------------------------------
// variable_length_code_packer_top
// Looks up symbol codes in a loaded table and packs them LSB first into
// words; finish flushes the partial word with the total bit count.
//
// channel   direction  carries
// sym       in         sym_item_t: load entry, encode symbol, or finish
// word      out        word_item_t: full word, or final word on finish
// cfg       in         buffer_words, 16 bits
//
// One item per cycle sustained while the word output is not stalled;
// an accepted item's table read is registered, then the shift-or merges
// its code into the current word register and registers any emitted
// word; a stalled word output can hold the item between those steps.
// Reset clears the packer state and sets buffer_words to 65535; the table
// holds nothing defined until loaded. A stalled word output holds one
// item in the lookup stage before sym_ready drops.
// ----------------------------------------------------------------------------
module variable_length_code_packer_top #(
	parameter int SYMBOL_BITS   = vlcp_pkg::DEF_SYMBOL_BITS,
	parameter int WORD_BITS     = vlcp_pkg::DEF_WORD_BITS,
	parameter int MAX_CODE_BITS = vlcp_pkg::DEF_MAX_CODE_BITS
) (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 sym_valid,
	output logic                 sym_ready,
	input  vlcp_pkg::sym_item_t  sym_item,
	output logic                 word_valid,
	input  logic                 word_ready,
	output vlcp_pkg::word_item_t word_item,
	input  logic                 cfg_valid,
	output logic                 cfg_ready,
	input  logic [15:0]          cfg_data
);
	import vlcp_pkg::*;

	localparam int CODE_W = (MAX_CODE_BITS < WORD_BITS) ? MAX_CODE_BITS : WORD_BITS;
	localparam int LEN_W  = $clog2(CODE_W + 1);

	logic [15:0]            buffer_words_q;
	logic                   s1_free;
	logic                   sym_acc;
	issue_t                 issue;
	logic [SYMBOL_BITS-1:0] addr;
	logic [LEN_W-1:0]       load_len;
	logic [31:0]            load_mask;
	logic [CODE_W-1:0]      load_code;
	logic [CODE_W-1:0]      rd_code;
	logic [LEN_W-1:0]       rd_len;

	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			buffer_words_q <= BUFFER_WORDS_RESET;
		end else if (cfg_valid && cfg_ready) begin
			buffer_words_q <= cfg_data;
		end
	end

	assign sym_ready = s1_free;
	assign sym_acc   = sym_valid && sym_ready;
	assign addr      = SYMBOL_BITS'(sym_item.symbol);

	always_comb begin
		issue.valid = 1'b0;
		issue.cmd   = cmd_t'(sym_item.cmd);
		unique case (sym_item.cmd)
			CMD_ENCODE, CMD_FINISH: issue.valid = sym_acc;
			default:                issue.valid = 1'b0;
		endcase
	end

	always_comb begin
		load_len  = (sym_item.code_length > 6'(CODE_W)) ? LEN_W'(CODE_W)
		                                                : LEN_W'(sym_item.code_length);
		load_mask = (6'(load_len) >= 6'd32) ? '1 : (32'd1 << load_len) - 32'd1;
		load_code = CODE_W'(sym_item.code_bits & load_mask);
	end

	vlcp_table #(
		.ADDR_W (SYMBOL_BITS),
		.CODE_W (CODE_W),
		.LEN_W  (LEN_W)
	) u_table (
		.clk     (clk),
		.wr_en   (sym_acc && sym_item.cmd == CMD_LOAD),
		.wr_addr (addr),
		.wr_code (load_code),
		.wr_len  (load_len),
		.rd_en   (issue.valid),
		.rd_addr (addr),
		.rd_code (rd_code),
		.rd_len  (rd_len)
	);

	vlcp_packer #(
		.WORD_BITS (WORD_BITS),
		.CODE_W    (CODE_W),
		.LEN_W     (LEN_W)
	) u_packer (
		.clk          (clk),
		.arst_n       (arst_n),
		.buffer_words (buffer_words_q),
		.issue        (issue),
		.s1_free      (s1_free),
		.rd_code      (rd_code),
		.rd_len       (rd_len),
		.word_valid   (word_valid),
		.word_ready   (word_ready),
		.word_item    (word_item)
	);

endmodule
